[design/fcc_pkg.sv]
// shared constants and types for the cmap character coverage block
package fcc_pkg;

   localparam int unsigned STORE_BYTES_DEF = 65536;
   localparam int unsigned AW_MAX          = 34;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [4:0] {
      FMT_NONE = 5'b00001,
      FMT_F2   = 5'b00010,
      FMT_F4   = 5'b00100,
      FMT_F6   = 5'b01000,
      FMT_F12  = 5'b10000
   } fmt_type;

   // request from the walk sequencer to the byte fetch unit
   typedef struct packed {
      logic              start;
      logic [AW_MAX-1:0] addr;
      logic [2:0]        len;
   } fetch_req_type;

   // answer from the fetch unit
   typedef struct packed {
      logic        done;
      logic        fault;
      logic [31:0] data;
   } fetch_rsp_type;

endpackage

[design/font_cmap_char_coverage.sv]
// top level of the cmap character coverage block
// Usage: req_ items either write one table byte (req_operation 0) or ask
// whether a character is mapped (req_operation 1). A write gives no result.
// A query walks the cmap header, the encoding records and the chosen
// subtables, reading the byte store one byte at a time through a single
// fetch unit that spends an address step and a data step on each byte;
// the walk grows with the length of the segment or group lists that it
// searches. req_stall stays high while a query walks and
// while its result waits. rsp_valid holds covered and bad_access in a
// register until the receiver drops rsp_stall; the next item is taken once
// the result has left. Reset clears all control state; the byte store is
// not cleared and must be written before a query reads it. A byte at or
// beyond STORE_BYTES gives bad_access 1 with covered 0.
module font_cmap_char_coverage #(
   parameter int unsigned STORE_BYTES = fcc_pkg::STORE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_byte_address,
   input  logic [7:0]  req_byte_value,
   input  logic [15:0] req_character,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_covered,
   output logic        rsp_bad_access
);
   import fcc_pkg::*;

   fetch_req_type freq;
   fetch_rsp_type frsp;
   logic busy_ff, busy_in;
   logic vld_ff, vld_in;
   logic cov_ff, bad_ff;
   logic acc, wdone, whit, wflt;

   assign req_stall = busy_ff || vld_ff;
   assign acc = req_valid && !req_stall;

   fcc_fetch #(.STORE_BYTES(STORE_BYTES)) u_fetch (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (acc && req_operation == OP_WRITE),
      .wr_addr (req_byte_address),
      .wr_data (req_byte_value),
      .req     (freq),
      .rsp     (frsp)
   );

   fcc_walk u_walk (
      .clock (clock),
      .reset (reset),
      .start (acc && req_operation == OP_QUERY),
      .ch    (req_character),
      .done  (wdone),
      .hit   (whit),
      .fault (wflt),
      .freq  (freq),
      .frsp  (frsp)
   );

   always_comb begin
      busy_in = busy_ff;
      vld_in  = vld_ff;
      if (acc && req_operation == OP_QUERY) busy_in = 1'b1;
      if (wdone) begin
         busy_in = 1'b0;
         vld_in  = 1'b1;
      end
      if (vld_ff && !rsp_stall) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
      end
      if (wdone) begin
         cov_ff <= whit && !wflt;
         bad_ff <= wflt;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_covered    = cov_ff;
   assign rsp_bad_access = bad_ff;

endmodule

[design/fcc_fetch.sv]
// byte store with a big-endian multi-byte read sequencer
module fcc_fetch #(
   parameter int unsigned STORE_BYTES = fcc_pkg::STORE_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [15:0]           wr_addr,
   input  logic [7:0]            wr_data,
   input  fcc_pkg::fetch_req_type req,
   output fcc_pkg::fetch_rsp_type rsp
);
   import fcc_pkg::*;

   localparam int unsigned IW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rd_ff;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_ADDR = 4'b0010,
      F_DATA = 4'b0100,
      F_DONE = 4'b1000
   } fst_type;

   fst_type           st_ff, st_in;
   logic [AW_MAX-1:0] a_ff, a_in;
   logic [2:0]        n_ff, n_in;
   logic [31:0]       d_ff, d_in;
   logic              flt_ff, flt_in;
   logic              in_range;
   logic [AW_MAX-1:0] wr_ext;

   assign wr_ext = {{(AW_MAX-16){1'b0}}, wr_addr};

   always_ff @(posedge clock) begin
      if (wr_en && (wr_ext < AW_MAX'(STORE_BYTES))) begin
         mem[wr_ext[IW-1:0]] <= wr_data;
      end
      rd_ff <= mem[a_ff[IW-1:0]];
   end

   // the whole span must lie inside the store
   assign in_range = ({1'b0, req.addr} + (AW_MAX+1)'(req.len)) <=
                     (AW_MAX+1)'(STORE_BYTES);

   always_comb begin
      st_in  = st_ff;
      a_in   = a_ff;
      n_in   = n_ff;
      d_in   = d_ff;
      flt_in = flt_ff;
      unique case (st_ff)
         F_IDLE: begin
            if (req.start) begin
               a_in   = req.addr;
               n_in   = req.len;
               d_in   = '0;
               flt_in = !in_range;
               st_in  = in_range ? F_ADDR : F_DONE;
            end
         end
         F_ADDR: st_in = F_DATA;
         F_DATA: begin
            d_in = {d_ff[23:0], rd_ff};
            n_in = n_ff - 3'd1;
            a_in = a_ff + AW_MAX'(1);
            st_in = (n_ff == 3'd1) ? F_DONE : F_ADDR;
         end
         F_DONE: st_in = F_IDLE;
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      a_ff   <= a_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      flt_ff <= flt_in;
   end

   assign rsp.done  = (st_ff == F_DONE);
   assign rsp.fault = flt_ff;
   assign rsp.data  = d_ff;

endmodule

[design/fcc_walk.sv]
// query sequencer walking encoding records and subtables
module fcc_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [15:0]           ch,
   output logic                  done,
   output logic                  hit,
   output logic                  fault,
   output fcc_pkg::fetch_req_type freq,
   input  fcc_pkg::fetch_rsp_type frsp
);
   import fcc_pkg::*;

   typedef enum logic [26:0] {
      W_IDLE  = 27'd1 << 0,
      W_VER   = 27'd1 << 1,
      W_CNT   = 27'd1 << 2,
      W_LOOP  = 27'd1 << 3,
      W_PLAT  = 27'd1 << 4,
      W_ENC   = 27'd1 << 5,
      W_OFF   = 27'd1 << 6,
      W_FMT   = 27'd1 << 7,
      W_DISP  = 27'd1 << 8,
      W_2K    = 27'd1 << 9,
      W_2A    = 27'd1 << 10,
      W_2B    = 27'd1 << 11,
      W_2C    = 27'd1 << 12,
      W_4SEG  = 27'd1 << 13,
      W_4END  = 27'd1 << 14,
      W_4STA  = 27'd1 << 15,
      W_4IRO  = 27'd1 << 16,
      W_4DEL  = 27'd1 << 17,
      W_4ADR  = 27'd1 << 18,
      W_4GLY  = 27'd1 << 19,
      W_6A    = 27'd1 << 20,
      W_6B    = 27'd1 << 21,
      W_12N   = 27'd1 << 22,
      W_12LO  = 27'd1 << 23,
      W_12HI  = 27'd1 << 24,
      W_NEXT  = 27'd1 << 25,
      W_FIN   = 27'd1 << 26
   } wst_type;

   wst_type           st_ff, st_in;
   logic              busy_ff, busy_in;  // fetch issued, waiting
   logic [15:0]       ver_ff, ver_in;
   logic [15:0]       cnt_ff, cnt_in;
   logic [15:0]       i_ff, i_in;
   logic [15:0]       plat_ff, plat_in;
   logic [15:0]       enc_ff, enc_in;
   logic [AW_MAX-1:0] sub_ff, sub_in;
   logic [AW_MAX-1:0] p_ff, p_in;      // walking pointer
   logic [AW_MAX-1:0] q_ff, q_in;      // auxiliary address
   logic [31:0]       j_ff, j_in;      // segment/group counter
   logic [31:0]       lim_ff, lim_in;
   logic [15:0]       a_ff, a_in;      // scratch words
   logic [15:0]       b_ff, b_in;
   logic [16:0]       c_ff, c_in;
   logic [31:0]       g_ff, g_in;
   fmt_type           fmt_ff, fmt_in;
   logic              hit_ff, hit_in;
   logic              flt_ff, flt_in;
   logic [15:0]       ch_ff;

   logic [AW_MAX-1:0] f_addr;
   logic [2:0]        f_len;
   logic [31:0]       fd;
   logic [15:0]       fw;

   assign fd = frsp.data;
   assign fw = frsp.data[15:0];

   always_ff @(posedge clock) begin
      if (start) ch_ff <= ch;
   end

   always_comb begin
      st_in   = st_ff;
      busy_in = busy_ff;
      ver_in  = ver_ff;
      cnt_in  = cnt_ff;
      i_in    = i_ff;
      plat_in = plat_ff;
      enc_in  = enc_ff;
      sub_in  = sub_ff;
      p_in    = p_ff;
      q_in    = q_ff;
      j_in    = j_ff;
      lim_in  = lim_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      g_in    = g_ff;
      fmt_in  = fmt_ff;
      hit_in  = hit_ff;
      flt_in  = flt_ff;
      f_addr  = '0;
      f_len   = 3'd2;
      freq.start = 1'b0;

      // states that need a fetch: address per state
      unique case (st_ff)
         W_VER:  f_addr = '0;
         W_CNT:  f_addr = AW_MAX'(2);
         W_PLAT: f_addr = p_ff;
         W_ENC:  f_addr = p_ff + AW_MAX'(2);
         W_OFF: begin
            f_addr = p_ff + AW_MAX'(4);
            f_len  = 3'd4;
         end
         W_FMT:  f_addr = sub_ff;
         W_2K:   f_addr = sub_ff + AW_MAX'(6) + AW_MAX'({ch_ff[15:8], 1'b0});
         W_2A:   f_addr = q_ff;
         W_2B:   f_addr = q_ff + AW_MAX'(2);
         W_2C:   f_addr = q_ff + AW_MAX'(4);
         W_4SEG: f_addr = sub_ff + AW_MAX'(6);
         W_4END: f_addr = p_ff;
         W_4STA: f_addr = p_ff + AW_MAX'(lim_ff[15:0]) + AW_MAX'(2);
         W_4IRO: f_addr = q_ff;
         W_4DEL: f_addr = q_ff - AW_MAX'(lim_ff[15:0]);
         W_4GLY: f_addr = q_ff;
         W_6A:   f_addr = sub_ff + AW_MAX'(6);
         W_6B:   f_addr = sub_ff + AW_MAX'(8);
         W_12N: begin
            f_addr = sub_ff + AW_MAX'(12);
            f_len  = 3'd4;
         end
         W_12LO: begin
            f_addr = p_ff;
            f_len  = 3'd4;
         end
         W_12HI: begin
            f_addr = p_ff + AW_MAX'(4);
            f_len  = 3'd4;
         end
         default: f_addr = '0;
      endcase

      unique case (st_ff)
         W_IDLE: begin
            if (start) begin
               hit_in = 1'b0;
               flt_in = 1'b0;
               busy_in = 1'b0;
               st_in  = W_VER;
            end
         end
         W_LOOP: begin
            if (i_ff == cnt_ff) begin
               st_in = W_FIN;
            end else begin
               p_in  = AW_MAX'(4) + AW_MAX'({i_ff, 3'b000});
               st_in = W_PLAT;
            end
         end
         W_DISP: begin
            if (fmt_ff == FMT_NONE ||
                !(plat_ff == 16'd0 ||
                  (plat_ff == 16'd3 && (enc_ff == 16'd2 || enc_ff == 16'd10)))) begin
               st_in = W_NEXT;
            end else begin
               unique case (fmt_ff)
                  FMT_F2:  st_in = W_2K;
                  FMT_F4:  st_in = W_4SEG;
                  FMT_F6:  st_in = W_6A;
                  FMT_F12: st_in = W_12N;
                  default: st_in = W_NEXT;
               endcase
            end
         end
         W_4ADR: begin
            // glyph array word address
            q_in  = q_ff + AW_MAX'({a_ff[15:1], 1'b0}) +
                    AW_MAX'({ch_ff - b_ff, 1'b0});
            st_in = W_4GLY;
         end
         W_NEXT: begin
            if (hit_ff) begin
               st_in = W_FIN;
            end else begin
               i_in  = i_ff + 16'd1;
               st_in = W_LOOP;
            end
         end
         W_FIN: st_in = W_IDLE;
         default: begin
            // fetch states
            if (!busy_ff) begin
               freq.start = 1'b1;
               busy_in    = 1'b1;
            end else if (frsp.done) begin
               busy_in = 1'b0;
               if (frsp.fault) begin
                  flt_in = 1'b1;
                  hit_in = 1'b0;
                  st_in  = W_FIN;
               end else begin
                  unique case (st_ff)
                     W_VER: begin
                        ver_in = fw;
                        st_in  = W_CNT;
                     end
                     W_CNT: begin
                        cnt_in = (ver_ff != 16'd0 && fw == 16'd0) ? ver_ff : fw;
                        i_in   = '0;
                        st_in  = W_LOOP;
                     end
                     W_PLAT: begin
                        plat_in = fw;
                        st_in   = W_ENC;
                     end
                     W_ENC: begin
                        enc_in = fw;
                        st_in  = W_OFF;
                     end
                     W_OFF: begin
                        sub_in = AW_MAX'(fd);
                        st_in  = W_FMT;
                     end
                     W_FMT: begin
                        if (fw == 16'd2)       fmt_in = FMT_F2;
                        else if (fw == 16'd4)  fmt_in = FMT_F4;
                        else if (fw == 16'd6)  fmt_in = FMT_F6;
                        else if (fw == 16'd12) fmt_in = FMT_F12;
                        else                   fmt_in = FMT_NONE;
                        // format 0 and unknown formats are both skipped
                        st_in = W_DISP;
                     end
                     W_2K: begin
                        q_in = sub_ff + AW_MAX'(518) + AW_MAX'({fw[15:3], 3'b000});
                        if (fw[15:3] == 13'd0 && ch_ff[15:8] != 8'd0) begin
                           st_in = W_NEXT;
                        end else begin
                           a_in  = {3'b000, fw[15:3]};
                           st_in = W_2A;
                        end
                     end
                     W_2A: begin
                        b_in  = fw;
                        st_in = W_2B;
                     end
                     W_2B: begin
                        c_in = {1'b0, fw};
                        if (a_ff == 16'd0) begin
                           st_in = W_2C;
                        end else begin
                           hit_in = ({8'd0, ch_ff[7:0]} >= b_ff) &&
                                    ({9'd0, ch_ff[7:0]} < ({1'b0, b_ff} + {1'b0, fw}));
                           st_in  = W_NEXT;
                        end
                     end
                     W_2C: begin
                        hit_in = (b_ff == 16'd0) && (c_ff == 17'd256) && (fw == 16'd0);
                        st_in  = W_NEXT;
                     end
                     W_4SEG: begin
                        lim_in = {16'd0, fw};
                        j_in   = '0;
                        p_in   = sub_ff + AW_MAX'(14);
                        st_in  = (fw[15:1] == 15'd0) ? W_NEXT : W_4END;
                     end
                     W_4END: begin
                        if (fw < ch_ff) begin
                           j_in = j_ff + 32'd1;
                           p_in = p_ff + AW_MAX'(2);
                           st_in = (j_ff + 32'd1 == {17'd0, lim_ff[15:1]}) ?
                                   W_NEXT : W_4END;
                        end else begin
                           st_in = W_4STA;
                        end
                     end
                     W_4STA: begin
                        b_in = fw;
                        // ranges slot = ends + 3*segx2 + 2 + 2j
                        q_in = p_ff + AW_MAX'(lim_ff[15:0]) + AW_MAX'(lim_ff[15:0]) +
                               AW_MAX'(lim_ff[15:0]) + AW_MAX'(2);
                        st_in = (fw > ch_ff) ? W_NEXT : W_4IRO;
                     end
                     W_4IRO: begin
                        a_in  = fw;
                        st_in = W_4DEL;
                     end
                     W_4DEL: begin
                        c_in = {1'b0, fw};
                        if (a_ff == 16'd0) begin
                           hit_in = (fw + ch_ff) != 16'd0;
                           st_in  = W_NEXT;
                        end else begin
                           st_in = W_4ADR;
                        end
                     end
                     W_4GLY: begin
                        hit_in = (fw != 16'd0) && ((c_ff[15:0] + fw) != 16'd0);
                        st_in  = W_NEXT;
                     end
                     W_6A: begin
                        b_in  = fw;
                        st_in = W_6B;
                     end
                     W_6B: begin
                        hit_in = (ch_ff >= b_ff) &&
                                 ({1'b0, ch_ff} < ({1'b0, b_ff} + {1'b0, fw}));
                        st_in  = W_NEXT;
                     end
                     W_12N: begin
                        lim_in = fd;
                        j_in   = '0;
                        p_in   = sub_ff + AW_MAX'(16);
                        st_in  = (fd == 32'd0) ? W_NEXT : W_12LO;
                     end
                     W_12LO: begin
                        g_in  = fd;
                        st_in = W_12HI;
                     end
                     W_12HI: begin
                        if ({16'd0, ch_ff} >= g_ff && {16'd0, ch_ff} <= fd) begin
                           hit_in = 1'b1;
                           st_in  = W_NEXT;
                        end else begin
                           j_in  = j_ff + 32'd1;
                           p_in  = p_ff + AW_MAX'(12);
                           st_in = (j_ff + 32'd1 == lim_ff) ? W_NEXT : W_12LO;
                        end
                     end
                     default: st_in = W_FIN;
                  endcase
               end
            end
         end
      endcase
      freq.addr = f_addr;
      freq.len  = f_len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= W_IDLE;
         busy_ff <= 1'b0;
         hit_ff  <= 1'b0;
         flt_ff  <= 1'b0;
      end else begin
         st_ff   <= st_in;
         busy_ff <= busy_in;
         hit_ff  <= hit_in;
         flt_ff  <= flt_in;
      end
      ver_ff  <= ver_in;
      cnt_ff  <= cnt_in;
      i_ff    <= i_in;
      plat_ff <= plat_in;
      enc_ff  <= enc_in;
      sub_ff  <= sub_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      j_ff    <= j_in;
      lim_ff  <= lim_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      g_ff    <= g_in;
      fmt_ff  <= fmt_in;
   end

   assign done  = (st_ff == W_FIN);
   assign hit   = hit_ff;
   assign fault = flt_ff;

endmodule

[verif/tb_font_cmap_char_coverage.sv]
// testbench for the cmap character coverage block: table builds, coverage queries, checking
module tb_font_cmap_char_coverage;
   timeunit 1ns;
   timeprecision 1ps;

   import fcc_pkg::*;

   localparam int unsigned MEM_BYTES   = 65536;
   localparam int          IDLE_LIMIT  = 500000;
   localparam int          SLOT_BASE   = 'h100;
   localparam int          SLOT_SPAN   = 'h1000;
   localparam int          NOISE_BASE  = 'h8000;
   localparam int          FMT_OTHER   = 5;
   localparam int          FMT_ZERO    = 0;
   localparam int          FMT_RANDOM  = -1;

   // mirror of the byte store plus the cmap walk that decides coverage
   class coverage_scoreboard;
      bit [7:0] image [0:MEM_BYTES-1];
      bit       known [0:MEM_BYTES-1];
      bit       probing;
      int unsigned gaps [$];
      bit       walk_bad;
      bit [1:0] pending_q [$];   // {covered, bad_access}
      int       errors;

      function bit [31:0] fetch(longint unsigned a, int n);
         bit [31:0] v;
         v = 0;
         if (walk_bad || a + n > MEM_BYTES) begin
            walk_bad = 1;
            return 0;
         end
         for (int i = 0; i < n; i++) begin
            // collect bytes the walk needs that were never written
            if (probing && !known[a + i]) begin
               gaps.push_back(int'(a + i));
               known[a + i] = 1;
            end
            v = (v << 8) | image[a + i];
         end
         return v;
      endfunction

      function bit cover_f2(longint unsigned sub, bit [15:0] ch);
         longint unsigned heads, sh;
         int unsigned k, first, count, delta, hi, lo;
         hi = ch[15:8];
         lo = ch[7:0];
         heads = sub + 518;
         k = fetch(sub + 6 + 2 * hi, 2) / 8;
         if (walk_bad) return 0;
         if (k == 0) begin
            if (hi != 0) return 0;
            first = fetch(heads, 2);
            count = fetch(heads + 2, 2);
            delta = fetch(heads + 4, 2);
            if (walk_bad) return 0;
            return first == 0 && count == 256 && delta == 0;
         end
         sh = heads + 8 * longint'(k);
         first = fetch(sh, 2);
         count = fetch(sh + 2, 2);
         if (walk_bad) return 0;
         return first <= lo && lo < first + count;
      endfunction

      function bit cover_f4(longint unsigned sub, bit [15:0] ch);
         int unsigned segx2, segs, endc, startc, iro, delta, w;
         longint unsigned ends, starts, deltas, ranges, at;
         bit [15:0] glyph;
         segx2 = fetch(sub + 6, 2);
         segs = segx2 / 2;
         ends = sub + 14;
         starts = ends + segx2 + 2;
         deltas = starts + segx2;
         ranges = deltas + segx2;
         if (walk_bad) return 0;
         for (int unsigned j = 0; j < segs; j++) begin
            endc = fetch(ends + 2 * j, 2);
            if (walk_bad) return 0;
            if (endc < ch) continue;
            startc = fetch(starts + 2 * j, 2);
            if (walk_bad || startc > ch) return 0;
            iro = fetch(ranges + 2 * j, 2);
            delta = fetch(deltas + 2 * j, 2);
            if (walk_bad) return 0;
            glyph = 0;
            if (iro == 0) begin
               glyph = 16'(delta + ch);
            end else begin
               at = ranges + 2 * j + 2 * (iro / 2) + 2 * (ch - startc);
               w = fetch(at, 2);
               if (walk_bad) return 0;
               if (w != 0) glyph = 16'(delta + w);
            end
            return glyph != 0;
         end
         return 0;
      endfunction

      function bit cover_f6(longint unsigned sub, bit [15:0] ch);
         int unsigned first, count;
         first = fetch(sub + 6, 2);
         count = fetch(sub + 8, 2);
         if (walk_bad) return 0;
         return first <= ch && ch < first + count;
      endfunction

      function bit cover_f12(longint unsigned sub, bit [15:0] ch);
         longint unsigned groups, at;
         int unsigned lo, hi;
         groups = fetch(sub + 12, 4);
         at = sub + 16;
         for (longint unsigned j = 0; j < groups && !walk_bad; j++) begin
            lo = fetch(at, 4);
            hi = fetch(at + 4, 4);
            if (walk_bad) return 0;
            if (ch >= lo && ch <= hi) return 1;
            at += 12;
         end
         return 0;
      endfunction

      function bit walk_cmap(bit [15:0] ch);
         int unsigned version, count, plat, enc, fmt;
         longint unsigned rec, sub;
         bit has;
         version = fetch(0, 2);
         count = fetch(2, 2);
         if (walk_bad) return 0;
         // zero count with nonzero version: fields taken as swapped
         if (version != 0 && count == 0) count = version;
         for (int unsigned i = 0; i < count; i++) begin
            rec = 4 + 8 * longint'(i);
            plat = fetch(rec, 2);
            enc = fetch(rec + 2, 2);
            sub = fetch(rec + 4, 4);
            fmt = fetch(sub, 2);
            has = 0;
            if (walk_bad) return 0;
            if (fmt == 0) continue;
            if (!(plat == 0 || (plat == 3 && (enc == 2 || enc == 10)))) continue;
            case (fmt)
               2:       has = cover_f2(sub, ch);
               4:       has = cover_f4(sub, ch);
               6:       has = cover_f6(sub, ch);
               12:      has = cover_f12(sub, ch);
               default: has = 0;
            endcase
            if (walk_bad) return 0;
            if (has) return 1;
         end
         return 0;
      endfunction

      // unwritten bytes read as zero, so writing zero there keeps the walk unchanged
      function void find_gaps(bit [15:0] ch);
         gaps.delete();
         probing = 1;
         walk_bad = 0;
         void'(walk_cmap(ch));
         probing = 0;
         walk_bad = 0;
      endfunction

      function void note_item(logic op, logic [15:0] a, logic [7:0] v, logic [15:0] ch);
         bit hit;
         if (op == OP_WRITE) begin
            image[a] = v;
            known[a] = 1;
         end else begin
            walk_bad = 0;
            hit = walk_cmap(ch);
            pending_q.push_back({hit && !walk_bad, walk_bad});
         end
      endfunction

      function void check_result(logic cov, logic bad);
         bit [1:0] exp;
         if (pending_q.size() == 0) begin
            $error("result with no query outstanding: covered %0b bad_access %0b", cov, bad);
            errors++;
            return;
         end
         exp = pending_q.pop_front();
         if (cov !== exp[1]) begin
            $error("covered: expected %0b, got %0b", exp[1], cov);
            errors++;
         end
         if (bad !== exp[0]) begin
            $error("bad_access: expected %0b, got %0b", exp[0], bad);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = 1'b0;
   logic [15:0] req_byte_address = '0;
   logic [7:0]  req_byte_value = '0;
   logic [15:0] req_character = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_covered;
   logic        rsp_bad_access;

   coverage_scoreboard sb;
   int          burst_left;
   bit          no_gaps;
   int          stall_pct;
   int          idle_cycles;
   int unsigned hot [$];

   font_cmap_char_coverage dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_byte_address (req_byte_address),
      .req_byte_value   (req_byte_value),
      .req_character    (req_character),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_covered      (rsp_covered),
      .rsp_bad_access   (rsp_bad_access)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_covered, rsp_bad_access);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else if (!reset) begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic put_item(logic op, logic [15:0] a, logic [7:0] v, logic [15:0] ch);
      if (burst_left == 0) begin
         if (!no_gaps) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_byte_address <= a;
      req_byte_value <= v;
      req_character <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(op, a, v, ch);
      burst_left--;
   endtask

   task automatic wr8(int a, int v);
      put_item(OP_WRITE, 16'(a), 8'(v), 16'($urandom));
   endtask

   task automatic wr16(int a, int v);
      wr8(a, v >> 8);
      wr8(a + 1, v);
   endtask

   task automatic wr32(int a, int unsigned v);
      wr16(a, v >> 16);
      wr16(a + 2, v);
   endtask

   // every byte the query will read is written before the query goes out
   task automatic ask(int unsigned ch);
      int unsigned fill [$];
      sb.find_gaps(16'(ch));
      fill = sb.gaps;
      foreach (fill[i]) wr8(int'(fill[i]), 0);
      put_item(OP_QUERY, 16'($urandom), 8'($urandom), 16'(ch));
   endtask

   // sender holds off until every outstanding query has answered
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic note_hot(int c);
      if (c >= 0 && c <= 65535) hot.push_back(c);
   endtask

   task automatic build_f2(int base);
      int hi;
      wr16(base, 2);
      wr16(base + 6, 8 * $urandom_range(0, 2));
      for (int i = 0; i < 6; i++) begin
         hi = $urandom_range(0, 255);
         wr16(base + 6 + 2 * hi, 8 * $urandom_range(0, 2));
         note_hot(hi << 8 | $urandom_range(0, 255));
      end
      for (int k = 0; k < 3; k++) begin
         if (k == 0 && $urandom_range(0, 1)) begin
            wr16(base + 518, 0);
            wr16(base + 520, 256);
            wr16(base + 522, 0);
         end else begin
            wr16(base + 518 + 8 * k, $urandom_range(0, 255));
            wr16(base + 520 + 8 * k, $urandom_range(0, 300));
            wr16(base + 522 + 8 * k, $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535));
         end
      end
      note_hot($urandom_range(0, 255));
   endtask

   task automatic build_f4(int base);
      int segs, cur, st, en, ranges;
      segs = $urandom_range(1, 4);
      ranges = base + 14 + 6 * segs + 2;
      wr16(base, 4);
      wr16(base + 6, 2 * segs);
      cur = $urandom_range(0, 200);
      for (int j = 0; j < segs; j++) begin
         st = cur + $urandom_range(0, 50);
         en = st + $urandom_range(0, 15);
         if (j == segs - 1 && $urandom_range(0, 2) == 0) en = 65535;
         if (en > 65535) en = 65535;
         if (st > en) st = en;
         cur = en + 1 + $urandom_range(0, 3000);
         wr16(base + 14 + 2 * j, en);
         wr16(base + 16 + 2 * segs + 2 * j, $urandom_range(0, 9) == 0 ? en + 1 : st);
         wr16(base + 16 + 4 * segs + 2 * j, $urandom_range(0, 3) == 0 ? 0 : $urandom);
         // nonzero range offset points into the glyph array right after the offsets
         wr16(ranges + 2 * j,
              $urandom_range(0, 1) ? 0 : 2 * (segs - j) + 2 * $urandom_range(0, 3));
         note_hot(st); note_hot(en); note_hot(st - 1); note_hot(en + 1);
         if (cur > 65535) break;
      end
      for (int g = 0; g < 16; g++) wr16(ranges + 2 * segs + 2 * g,
                                         $urandom_range(0, 3) == 0 ? 0 : $urandom);
   endtask

   task automatic build_f6(int base);
      int first, count;
      first = $urandom_range(0, 65535);
      count = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 40);
      wr16(base, 6);
      wr16(base + 6, first);
      wr16(base + 8, count);
      note_hot(first); note_hot(first - 1); note_hot(first + count); note_hot(first + count - 1);
   endtask

   task automatic build_f12(int base);
      int groups, lo, hi;
      groups = $urandom_range(1, 4);
      wr16(base, 12);
      wr32(base + 12, groups);
      for (int g = 0; g < groups; g++) begin
         lo = $urandom_range(0, 65535);
         hi = lo + $urandom_range(0, 100);
         wr32(base + 16 + 12 * g, lo);
         wr32(base + 20 + 12 * g, $urandom_range(0, 15) == 0 ? $urandom : hi);
         note_hot(lo); note_hot(hi); note_hot(lo - 1); note_hot(hi + 1);
      end
   endtask

   // header, records and subtables; fmt FMT_RANDOM picks per record
   task automatic build_table(int fmt, int nrec, bit swap, bit faults);
      int f, plat, enc, base;
      int unsigned off;
      hot.delete();
      if (swap) begin
         wr16(0, nrec);
         wr16(2, 0);
      end else begin
         wr16(0, 0);
         wr16(2, nrec);
      end
      for (int i = 0; i < nrec; i++) begin
         base = SLOT_BASE + i * SLOT_SPAN;
         f = fmt;
         if (f == FMT_RANDOM) begin
            case ($urandom_range(0, 5))
               0: f = 2;  1: f = 4;  2: f = 6;  3: f = 12;
               4: f = FMT_ZERO;
               default: f = FMT_OTHER;
            endcase
         end
         case ($urandom_range(0, 6))
            0, 1: begin plat = 0; enc = $urandom_range(0, 65535); end
            2, 3: begin plat = 3; enc = 2; end
            4:    begin plat = 3; enc = 10; end
            5:    begin plat = 3; enc = $urandom_range(0, 1) ? 1 : 65535; end
            default: begin plat = $urandom_range(0, 1) ? 1 : 65535; enc = 0; end
         endcase
         if (i == 0 && fmt != FMT_RANDOM) begin plat = 0; enc = 3; end
         off = base;
         if (faults && $urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
               0: off = 32'hFFFF_FFF0;
               1: off = MEM_BYTES - 1;
               2: off = MEM_BYTES - 2;
               default: begin
                  // group list running off the end of the store
                  off = 65000;
                  wr16(off, 12);
                  wr32(off + 12, 32'hFFFF_FFFF);
                  plat = 0;
               end
            endcase
            if (off == MEM_BYTES - 2) wr16(off, $urandom_range(0, 1) ? 6 : 12);
         end else begin
            case (f)
               2:        build_f2(base);
               4:        build_f4(base);
               6:        build_f6(base);
               12:       build_f12(base);
               FMT_ZERO: wr16(base, 0);
               default:  wr16(base, $urandom_range(0, 1) ? FMT_OTHER : 65535);
            endcase
         end
         wr16(4 + 8 * i, plat);
         wr16(6 + 8 * i, enc);
         wr32(8 + 8 * i, off);
      end
   endtask

   task automatic ask_some(int n);
      int c;
      for (int q = 0; q < n; q++) begin
         if (hot.size() != 0 && $urandom_range(0, 9) < 7)
            c = hot[$urandom_range(0, hot.size() - 1)];
         else
            c = $urandom_range(0, 65535);
         ask(c);
      end
   endtask

   initial begin
      sb = new;
      burst_left = 0;
      no_gaps = 0;
      stall_pct = 0;
      idle_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      stall_pct = 30;

      // empty table
      ask(0); ask(65535);
      settle();

      // one phase per format (the format 6 phase with a swapped header), then faulting offsets
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: build_table(2, 1, 0, 0);
            1: build_table(4, 1, 0, 0);
            2: build_table(6, 1, 1, 0);
            3: build_table(12, 2, 0, 0);
            4: build_table(FMT_ZERO, 1, 0, 0);
            default: build_table(FMT_OTHER, 1, 0, 0);
         endcase
         ask(0); ask(65535);
         ask_some(4);
         settle();
      end
      stall_pct = 90;
      build_table(FMT_RANDOM, 3, 0, 1);
      ask_some(6);
      settle();

      // random phases: random tables with some faulting offsets, noise and damaged subtables
      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0: stall_pct = 0;
            1: stall_pct = $urandom_range(10, 50);
            2: stall_pct = 95;
            default: stall_pct = $urandom_range(0, 99);
         endcase
         no_gaps = (p % 5 == 0);
         build_table(FMT_RANDOM, $urandom_range(0, 4), $urandom_range(0, 3) == 0, 1);
         for (int n = 0; n < 8; n++) wr8($urandom_range(NOISE_BASE, 65535), $urandom);
         // damage stays past the group count so group lists keep their length
         if ($urandom_range(0, 3) == 0)
            wr8(SLOT_BASE + $urandom_range(0, 3) * SLOT_SPAN + $urandom_range(16, 80),
                $urandom);
         ask_some($urandom_range(30, 60));
         if (p % 3 == 0) settle();
      end

      settle();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
